FILE: rtl/clbs_pkg.sv
// Shared types, constants and byte tables for the character-LCD bus sequencer.
`default_nettype none
package clbs_pkg;

  // Request codes on the input channel.
  localparam logic [2:0] CMD_INIT      = 3'd0;
  localparam logic [2:0] CMD_COMMAND   = 3'd1;
  localparam logic [2:0] CMD_DATA      = 3'd2;
  localparam logic [2:0] CMD_DATA_AT   = 3'd3;
  localparam logic [2:0] CMD_GLYPH_SEL = 3'd4;

  // Row codes for data at position.
  localparam logic [2:0] ROW_1 = 3'd1;
  localparam logic [2:0] ROW_2 = 3'd2;
  localparam logic [2:0] ROW_3 = 3'd3;
  localparam logic [2:0] ROW_4 = 3'd4;

  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;
  localparam logic [7:0] ROW3_BASE = 8'h94;
  localparam logic [7:0] ROW4_BASE = 8'hD4;

  localparam logic [7:0] GLYPH_BASE = 8'h40;

  localparam logic [7:0] FUNC_SET_4BIT = 8'h28;
  localparam logic [7:0] FUNC_SET_8BIT = 8'h38;
  localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
  localparam logic [7:0] RETURN_HOME   = 8'h02;
  localparam logic [7:0] ENTRY_MODE    = 8'h06;
  localparam logic [7:0] DISPLAY_ON    = 8'h0C;
  localparam logic [7:0] SET_DDRAM_0   = 8'h80;

  localparam logic [14:0] WAIT_POWER_UP = 15'd20000;
  localparam logic [14:0] WAIT_SECOND   = 15'd5000;
  localparam logic [14:0] WAIT_THIRD    = 15'd150;
  localparam logic [14:0] WAIT_NONE     = 15'd0;

  localparam logic [3:0] INIT_LAST_IDX = 4'd8;

  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_ONE,
    JOB_TWO
  } job_kind_t;

  // One queued request: up to two bytes, or the whole init sequence.
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] byte_a;
    logic       rs_a;
    logic [7:0] byte_b;
    logic       rs_b;
  } job_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] init_byte(input logic [3:0] idx, input logic four_bit);
    logic [7:0] mode_cmd;
    logic [7:0] b;
    mode_cmd = four_bit ? FUNC_SET_4BIT : FUNC_SET_8BIT;
    case (idx)
      4'd3:    b = CLEAR_DISPLAY;
      4'd4:    b = RETURN_HOME;
      4'd5:    b = ENTRY_MODE;
      4'd6:    b = DISPLAY_ON;
      4'd8:    b = SET_DDRAM_0;
      default: b = mode_cmd;
    endcase
    return b;
  endfunction

  function automatic logic [14:0] init_wait(input logic [3:0] idx);
    logic [14:0] w;
    case (idx)
      4'd0:    w = WAIT_POWER_UP;
      4'd1:    w = WAIT_SECOND;
      4'd2:    w = WAIT_THIRD;
      default: w = WAIT_NONE;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/clbs_ifs.sv
// Valid/ready channel interfaces for requests and bus strobes.
`default_nettype none
interface clbs_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] byte_value;
  logic [2:0] row;
  logic [7:0] column;
  logic [2:0] glyph_slot;

  modport source (output valid, cmd, byte_value, row, column, glyph_slot, input ready);
  modport sink   (input valid, cmd, byte_value, row, column, glyph_slot, output ready);
endinterface

interface clbs_strobe_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [7:0]  bus_value;
  logic [14:0] wait_before_us;
  logic        last;

  modport source (output valid, reg_select, bus_value, wait_before_us, last, input ready);
  modport sink   (input valid, reg_select, bus_value, wait_before_us, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/char_lcd_bus_sequencer_core.sv
// A request's job is first written into the job queue, and its first strobe word is then registered in the output word.
// Throughput: one strobe word per cycle from the strobe generator while the receiver is ready; a 4-bit byte
// takes two words, an 8-bit byte one, initialization 18 or 9 words.
// The job queue (QUEUE_DEPTH entries) lets requests be accepted while strobes drain.
// Synchronous active-low reset empties the queue and output and sets 4-bit mode.
`default_nettype none
module char_lcd_bus_sequencer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  clbs_req_if.sink        in_req,
  clbs_strobe_if.source   out_strobe
);

  logic                    four_bit_r;
  logic                    push;
  logic                    pop;
  clbs_pkg::job_t          push_job;
  clbs_pkg::job_t          head_job;
  clbs_pkg::queue_status_t q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_r <= 1'b1;
    end else if (cfg_we) begin
      four_bit_r <= cfg_wdata;
    end
  end

  clbs_front u_front (
    .in_valid   (in_req.valid),
    .in_ready   (in_req.ready),
    .cmd        (in_req.cmd),
    .byte_value (in_req.byte_value),
    .row        (in_req.row),
    .column     (in_req.column),
    .glyph_slot (in_req.glyph_slot),
    .q_status   (q_status),
    .push       (push),
    .job        (push_job)
  );

  clbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  clbs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .four_bit       (four_bit_r),
    .head_job       (head_job),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_strobe.valid),
    .out_ready      (out_strobe.ready),
    .reg_select     (out_strobe.reg_select),
    .bus_value      (out_strobe.bus_value),
    .wait_before_us (out_strobe.wait_before_us),
    .last           (out_strobe.last)
  );

endmodule
`default_nettype wire

FILE: rtl/clbs_front.sv
// Front end: accepts request words and turns them into queued jobs.
`default_nettype none
module clbs_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         cmd,
  input  wire logic [7:0]         byte_value,
  input  wire logic [2:0]         row,
  input  wire logic [7:0]         column,
  input  wire logic [2:0]         glyph_slot,
  input  wire clbs_pkg::queue_status_t q_status,
  output logic                    push,
  output clbs_pkg::job_t          job
);

  logic       known;
  logic [7:0] row_base;
  logic       row_ok;

  always_comb begin
    row_ok = 1'b1;
    unique case (row)
      clbs_pkg::ROW_1: row_base = clbs_pkg::ROW1_BASE;
      clbs_pkg::ROW_2: row_base = clbs_pkg::ROW2_BASE;
      clbs_pkg::ROW_3: row_base = clbs_pkg::ROW3_BASE;
      clbs_pkg::ROW_4: row_base = clbs_pkg::ROW4_BASE;
      default: begin
        row_base = 8'h00;
        row_ok   = 1'b0;
      end
    endcase
  end

  always_comb begin
    known       = 1'b1;
    job.kind    = clbs_pkg::JOB_ONE;
    job.byte_a  = byte_value;
    job.rs_a    = clbs_pkg::RS_COMMAND;
    job.byte_b  = byte_value;
    job.rs_b    = clbs_pkg::RS_DATA;
    unique case (cmd)
      clbs_pkg::CMD_INIT:    job.kind = clbs_pkg::JOB_INIT;
      clbs_pkg::CMD_COMMAND: job.rs_a = clbs_pkg::RS_COMMAND;
      clbs_pkg::CMD_DATA:    job.rs_a = clbs_pkg::RS_DATA;
      clbs_pkg::CMD_DATA_AT: begin
        // Cursor address is base + column - 1, wrapping at 256.
        if (row_ok) begin
          job.kind   = clbs_pkg::JOB_TWO;
          job.byte_a = row_base + column + 8'hFF;
        end else begin
          job.rs_a = clbs_pkg::RS_DATA;
        end
      end
      clbs_pkg::CMD_GLYPH_SEL: job.byte_a = clbs_pkg::GLYPH_BASE + {2'b00, glyph_slot, 3'b000};
      default: known = 1'b0;
    endcase
  end

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready && known;

endmodule
`default_nettype wire

FILE: rtl/clbs_queue.sv
// Small job queue between the front end and the strobe generator.
`default_nettype none
module clbs_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire clbs_pkg::job_t        push_job,
  input  wire logic                  pop,
  output clbs_pkg::job_t             head_job,
  output clbs_pkg::queue_status_t    status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  clbs_pkg::job_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  assign head_job     = mem[rd_ptr_r];
  assign status.full  = (count_r == FULL_CNT);
  assign status.empty = (count_r == '0);

endmodule
`default_nettype wire

FILE: rtl/clbs_back.sv
// Back end: walks the head job byte by byte and nibble by nibble into strobes.
`default_nettype none
module clbs_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    four_bit,
  input  wire clbs_pkg::job_t          head_job,
  input  wire clbs_pkg::queue_status_t q_status,
  output logic                         pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         reg_select,
  output logic [7:0]                   bus_value,
  output logic [14:0]                  wait_before_us,
  output logic                         last
);

  logic [3:0]  idx_r, idx_nxt;
  logic        nib_r, nib_nxt;
  logic        valid_r, valid_nxt;
  logic        rs_r;
  logic [7:0]  val_r;
  logic [14:0] wait_r;
  logic        last_r;

  logic        advance;
  logic [7:0]  cur_byte;
  logic        cur_rs;
  logic [14:0] cur_wait;
  logic        last_byte;
  logic        last_strobe;
  logic [7:0]  cur_val;

  always_comb begin
    cur_wait = clbs_pkg::WAIT_NONE;
    unique case (head_job.kind)
      clbs_pkg::JOB_INIT: begin
        cur_byte  = clbs_pkg::init_byte(idx_r, four_bit);
        cur_rs    = clbs_pkg::RS_COMMAND;
        last_byte = (idx_r == clbs_pkg::INIT_LAST_IDX);
        if (!nib_r) cur_wait = clbs_pkg::init_wait(idx_r);
      end
      clbs_pkg::JOB_TWO: begin
        cur_byte  = (idx_r == 4'd0) ? head_job.byte_a : head_job.byte_b;
        cur_rs    = (idx_r == 4'd0) ? head_job.rs_a : head_job.rs_b;
        last_byte = (idx_r != 4'd0);
      end
      default: begin
        cur_byte  = head_job.byte_a;
        cur_rs    = head_job.rs_a;
        last_byte = 1'b1;
      end
    endcase
    if (four_bit) cur_val = nib_r ? {4'h0, cur_byte[3:0]} : {4'h0, cur_byte[7:4]};
    else          cur_val = cur_byte;
    last_strobe = last_byte && (nib_r || !four_bit);
  end

  // A strobe is produced whenever a job is waiting and the output word is free.
  assign advance = !q_status.empty && (!valid_r || out_ready);
  assign pop     = advance && last_strobe;

  always_comb begin
    idx_nxt   = idx_r;
    nib_nxt   = nib_r;
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
      if (last_strobe) begin
        idx_nxt = '0;
        nib_nxt = 1'b0;
      end else if (four_bit && !nib_r) begin
        nib_nxt = 1'b1;
      end else begin
        nib_nxt = 1'b0;
        idx_nxt = idx_r + 1'b1;
      end
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      nib_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      nib_r   <= nib_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rs_r   <= cur_rs;
      val_r  <= cur_val;
      wait_r <= cur_wait;
      last_r <= last_strobe;
    end
  end

  assign out_valid      = valid_r;
  assign reg_select     = rs_r;
  assign bus_value      = val_r;
  assign wait_before_us = wait_r;
  assign last           = last_r;

endmodule
`default_nettype wire

FILE: tb/char_lcd_bus_sequencer_core_test.sv
// Self-checking testbench for char_lcd_bus_sequencer_core with random and directed requests.
`timescale 1ns / 1ps

module char_lcd_bus_sequencer_core_test;

  // Request codes that the block must ignore.
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam logic [2:0] ROW_NONE    = 3'd0;
  localparam logic [2:0] ROW_TOP     = 3'd7;
  localparam int         PHASE_ITEMS = 86;
  localparam int         SETTLE_CYCLES = 8;

  typedef struct {
    logic [2:0] cmd;
    logic [7:0] byte_value;
    logic [2:0] row;
    logic [7:0] column;
    logic [2:0] glyph_slot;
  } lcd_request_t;

  typedef struct {
    logic        reg_select;
    logic [7:0]  bus_value;
    logic [14:0] wait_before_us;
    logic        last;
  } lcd_strobe_t;

  class lcd_strobe_scoreboard;
    logic        four_bit_mode = 1'b1;
    lcd_strobe_t expected_strobes[$];
    int          mismatch_count = 0;

    function int pending();
      return expected_strobes.size();
    endfunction

    // One byte becomes two nibble words in 4-bit mode, else one word.
    function void add_byte(ref lcd_strobe_t seq[$], input logic rs, input logic [7:0] b,
                           input logic [14:0] wait_us);
      lcd_strobe_t s;
      s.reg_select = rs;
      s.last = 1'b0;
      s.wait_before_us = wait_us;
      if (four_bit_mode) begin
        s.bus_value = {4'h0, b[7:4]};
        seq.push_back(s);
        s.bus_value = {4'h0, b[3:0]};
        s.wait_before_us = clbs_pkg::WAIT_NONE;
        seq.push_back(s);
      end else begin
        s.bus_value = b;
        seq.push_back(s);
      end
    endfunction

    function void note_request(lcd_request_t r);
      lcd_strobe_t seq[$];
      logic [7:0]  func_set;
      logic [7:0]  row_base;
      logic        cursor_move;
      func_set = four_bit_mode ? clbs_pkg::FUNC_SET_4BIT : clbs_pkg::FUNC_SET_8BIT;
      cursor_move = 1'b1;
      row_base = clbs_pkg::ROW1_BASE;
      case (r.cmd)
        clbs_pkg::CMD_INIT: begin
          add_byte(seq, clbs_pkg::RS_COMMAND, func_set, clbs_pkg::WAIT_POWER_UP);
          add_byte(seq, clbs_pkg::RS_COMMAND, func_set, clbs_pkg::WAIT_SECOND);
          add_byte(seq, clbs_pkg::RS_COMMAND, func_set, clbs_pkg::WAIT_THIRD);
          add_byte(seq, clbs_pkg::RS_COMMAND, clbs_pkg::CLEAR_DISPLAY, clbs_pkg::WAIT_NONE);
          add_byte(seq, clbs_pkg::RS_COMMAND, clbs_pkg::RETURN_HOME, clbs_pkg::WAIT_NONE);
          add_byte(seq, clbs_pkg::RS_COMMAND, clbs_pkg::ENTRY_MODE, clbs_pkg::WAIT_NONE);
          add_byte(seq, clbs_pkg::RS_COMMAND, clbs_pkg::DISPLAY_ON, clbs_pkg::WAIT_NONE);
          add_byte(seq, clbs_pkg::RS_COMMAND, func_set, clbs_pkg::WAIT_NONE);
          add_byte(seq, clbs_pkg::RS_COMMAND, clbs_pkg::SET_DDRAM_0, clbs_pkg::WAIT_NONE);
        end
        clbs_pkg::CMD_COMMAND:
          add_byte(seq, clbs_pkg::RS_COMMAND, r.byte_value, clbs_pkg::WAIT_NONE);
        clbs_pkg::CMD_DATA:
          add_byte(seq, clbs_pkg::RS_DATA, r.byte_value, clbs_pkg::WAIT_NONE);
        clbs_pkg::CMD_DATA_AT: begin
          case (r.row)
            clbs_pkg::ROW_1: row_base = clbs_pkg::ROW1_BASE;
            clbs_pkg::ROW_2: row_base = clbs_pkg::ROW2_BASE;
            clbs_pkg::ROW_3: row_base = clbs_pkg::ROW3_BASE;
            clbs_pkg::ROW_4: row_base = clbs_pkg::ROW4_BASE;
            default:         cursor_move = 1'b0;
          endcase
          // Columns are one-based and the address wraps at 8 bits.
          if (cursor_move)
            add_byte(seq, clbs_pkg::RS_COMMAND, row_base + r.column - 8'd1,
                     clbs_pkg::WAIT_NONE);
          add_byte(seq, clbs_pkg::RS_DATA, r.byte_value, clbs_pkg::WAIT_NONE);
        end
        clbs_pkg::CMD_GLYPH_SEL:
          add_byte(seq, clbs_pkg::RS_COMMAND,
                   clbs_pkg::GLYPH_BASE + {2'b00, r.glyph_slot, 3'b000},
                   clbs_pkg::WAIT_NONE);
        default: ;
      endcase
      if (seq.size() > 0) begin
        seq[seq.size() - 1].last = 1'b1;
        foreach (seq[i]) expected_strobes.push_back(seq[i]);
      end
    endfunction

    task report(string msg);
      if (mismatch_count < 50) $display("strobe error at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    task check_strobe(lcd_strobe_t got);
      lcd_strobe_t want;
      if (expected_strobes.size() == 0) begin
        report($sformatf("unexpected word rs=%0b bus=%02h wait=%0d last=%0b",
                         got.reg_select, got.bus_value, got.wait_before_us, got.last));
      end else begin
        want = expected_strobes.pop_front();
        if (got.reg_select !== want.reg_select)
          report($sformatf("reg_select %0b, expected %0b", got.reg_select, want.reg_select));
        if (got.bus_value !== want.bus_value)
          report($sformatf("bus_value %02h, expected %02h", got.bus_value, want.bus_value));
        if (got.wait_before_us !== want.wait_before_us)
          report($sformatf("wait_before_us %0d, expected %0d",
                           got.wait_before_us, want.wait_before_us));
        if (got.last !== want.last)
          report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  clbs_req_if    req_ch();
  clbs_strobe_if strobe_ch();

  char_lcd_bus_sequencer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_ch),
    .out_strobe(strobe_ch)
  );

  lcd_strobe_scoreboard sb = new();

  bit quiet = 1'b0;
  bit sender_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int stall_left = 0;
  int zone_count = 0;

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("FAIL char_lcd_bus_sequencer_core");
    $finish;
  end

  // Words are checked before the request of the same edge is noted.
  always @(posedge clk) begin
    lcd_strobe_t got;
    lcd_request_t r;
    if (rst_n && strobe_ch.valid && strobe_ch.ready) begin
      got.reg_select = strobe_ch.reg_select;
      got.bus_value = strobe_ch.bus_value;
      got.wait_before_us = strobe_ch.wait_before_us;
      got.last = strobe_ch.last;
      sb.check_strobe(got);
    end
    if (rst_n && req_ch.valid && req_ch.ready) begin
      r.cmd = req_ch.cmd;
      r.byte_value = req_ch.byte_value;
      r.row = req_ch.row;
      r.column = req_ch.column;
      r.glyph_slot = req_ch.glyph_slot;
      sb.note_request(r);
    end
  end

  // Receiver stalls come in bursts, with calm stretches in between.
  always @(negedge clk) begin
    zone_count++;
    if (zone_count == 48) begin
      zone_count = 0;
      sink_stalls = ($urandom_range(0, 2) != 0);
    end
    if (stall_left > 0) begin
      strobe_ch.ready = 1'b0;
      stall_left--;
    end else if (!quiet && sink_stalls && $urandom_range(0, 3) == 0) begin
      strobe_ch.ready = 1'b0;
      stall_left = $urandom_range(1, 7) - 1;
    end else begin
      strobe_ch.ready = 1'b1;
    end
  end

  function automatic lcd_request_t make_req(logic [2:0] c, logic [7:0] b, logic [2:0] rw,
                                            logic [7:0] col, logic [2:0] s);
    lcd_request_t r;
    r.cmd = c;
    r.byte_value = b;
    r.row = rw;
    r.column = col;
    r.glyph_slot = s;
    return r;
  endfunction

  function automatic lcd_request_t random_request();
    lcd_request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.byte_value = 8'($urandom_range(0, 255));
    r.glyph_slot = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 4) != 0)
      r.row = 3'($urandom_range(clbs_pkg::ROW_1, clbs_pkg::ROW_4));
    else
      r.row = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0:       r.column = 8'd0;
      1:       r.column = 8'd1;
      2:       r.column = 8'hFF;
      default: r.column = 8'($urandom_range(0, 255));
    endcase
    if (pick < 5)       r.cmd = clbs_pkg::CMD_INIT;
    else if (pick < 25) r.cmd = clbs_pkg::CMD_COMMAND;
    else if (pick < 50) r.cmd = clbs_pkg::CMD_DATA;
    else if (pick < 80) r.cmd = clbs_pkg::CMD_DATA_AT;
    else if (pick < 92) r.cmd = clbs_pkg::CMD_GLYPH_SEL;
    else                r.cmd = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
    return r;
  endfunction

  task automatic drive_request(lcd_request_t r);
    if (!quiet && sender_gaps && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 7)) begin
        @(negedge clk);
        req_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.cmd = r.cmd;
    req_ch.byte_value = r.byte_value;
    req_ch.row = r.row;
    req_ch.column = r.column;
    req_ch.glyph_slot = r.glyph_slot;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop the request valid, let every expected word drain, then idle before going on.
  task automatic settle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic four_bit);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = four_bit;
    sb.four_bit_mode = four_bit;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_directed();
    drive_request(make_req(clbs_pkg::CMD_INIT, 8'h00, ROW_NONE, 8'h00, 3'd0));
    drive_request(make_req(clbs_pkg::CMD_COMMAND, 8'h00, ROW_TOP, 8'hFF, 3'd7));
    drive_request(make_req(clbs_pkg::CMD_COMMAND, 8'hFF, ROW_NONE, 8'h00, 3'd0));
    drive_request(make_req(clbs_pkg::CMD_DATA, 8'h00, clbs_pkg::ROW_1, 8'h00, 3'd0));
    drive_request(make_req(clbs_pkg::CMD_DATA, 8'hFF, ROW_TOP, 8'hFF, 3'd7));
    drive_request(make_req(clbs_pkg::CMD_DATA_AT, 8'h41, clbs_pkg::ROW_1, 8'd1, 3'd0));
    drive_request(make_req(clbs_pkg::CMD_DATA_AT, 8'h42, clbs_pkg::ROW_2, 8'd0, 3'd0));
    drive_request(make_req(clbs_pkg::CMD_DATA_AT, 8'hFF, clbs_pkg::ROW_3, 8'hFF, 3'd0));
    drive_request(make_req(clbs_pkg::CMD_DATA_AT, 8'h00, clbs_pkg::ROW_4, 8'd20, 3'd0));
    drive_request(make_req(clbs_pkg::CMD_DATA_AT, 8'h7E, ROW_NONE, 8'd5, 3'd0));
    drive_request(make_req(clbs_pkg::CMD_DATA_AT, 8'h81, ROW_TOP, 8'hFF, 3'd0));
    drive_request(make_req(clbs_pkg::CMD_GLYPH_SEL, 8'h00, ROW_NONE, 8'h00, 3'd0));
    drive_request(make_req(clbs_pkg::CMD_GLYPH_SEL, 8'hFF, ROW_NONE, 8'h00, 3'd7));
    drive_request(make_req(CMD_SPARE_5, 8'hA5, clbs_pkg::ROW_2, 8'h5A, 3'd5));
  endtask

  initial begin
    int count;
    lcd_request_t r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.cmd = clbs_pkg::CMD_INIT;
    req_ch.byte_value = 8'h00;
    req_ch.row = ROW_NONE;
    req_ch.column = 8'h00;
    req_ch.glyph_slot = 3'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_mode(1'b1);
    run_directed();
    settle();
    write_mode(1'b0);
    run_directed();
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      write_mode(phase % 2 == 0);
      quiet = (phase == 3);
      count = 0;
      while (count < PHASE_ITEMS) begin
        if (count % 32 == 0) sender_gaps = ($urandom_range(0, 2) != 0);
        r = random_request();
        count++;
        drive_request(r);
        if ($urandom_range(0, 99) == 0) settle();
      end
      settle();
    end

    if (sb.mismatch_count == 0)
      $display("PASS char_lcd_bus_sequencer_core");
    else
      $display("FAIL char_lcd_bus_sequencer_core");
    $finish;
  end

endmodule
